@@ src/key_scan_to_midi_encoder_unit_defines.svh @@
// Assertion macros shared by the key scan to MIDI encoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef KEY_SCAN_TO_MIDI_ENCODER_UNIT_DEFINES_SVH
`define KEY_SCAN_TO_MIDI_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define KSME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ksme assertion failed");

// next-cycle implication
`define KSME_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ksme assertion failed");

`endif

@@ src/ksme_pkg.sv @@
// Types and constants of the key scan to MIDI encoder.
// No dependencies; imported by every module of the block.
package ksme_pkg;

	localparam int POS_W = 4;
	localparam int NOTE_W = 7;
	localparam int MAX_MSGS = 3;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [NOTE_W-1:0] note_t;
	typedef logic [1:0] msg_cnt_t;

	localparam logic [7:0] NOTE_STATUS = 8'h90;
	localparam logic [7:0] CTRL_STATUS = 8'hB0;
	localparam note_t MOD_CONTROLLER = 7'h01;
	localparam note_t MAX_LEVEL = 7'h7F;
	localparam note_t MIN_LEVEL = 7'h00;
	localparam note_t OCTAVE = 7'd12;
	localparam note_t BASE_NOTE_RST = 7'h30;
	localparam pos_t NOTE_KEYS = 4'd13;
	localparam pos_t POS_VOL_DOWN = 4'd0;
	localparam pos_t POS_VOL_UP = 4'd1;
	localparam pos_t POS_VIBRATO = 4'd2;

	// register index (paddr[2])
	localparam logic REG_BASE_NOTE = 1'b0;

	typedef struct packed {
		logic [7:0] status;
		note_t      d1;
		note_t      d2;
	} msg_t;

	// held-flag write port: bit 0 row one, bit 1 row two
	typedef struct packed {
		logic       en;
		pos_t       addr;
		logic [1:0] data;
	} held_wr_t;

	// batch of messages from one sample, slot 0 first
	typedef struct packed {
		logic                      load;
		msg_cnt_t                  cnt;
		msg_t [MAX_MSGS-1:0]       msg;
	} msg_load_t;

endpackage

@@ src/ksme_held_mem.sv @@
// Held-flag memory: one 2-bit entry per scan position, registered read.
// Depends on ksme_pkg; valid bits stand in for the cleared reset state.
module ksme_held_mem #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  ksme_pkg::pos_t    rd_addr,
	input  ksme_pkg::held_wr_t wr,
	output logic [1:0]        rd_data
);
	import ksme_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [1:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [1:0]       mem_rdata_q;
	logic             vld_rd_q;
	logic             fwd_q;
	logic [1:0]       fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			mem_rdata_q <= mem[rd_addr[AW-1:0]];
			fwd_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_rd_q <= 1'b0;
			fwd_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= valid_q[rd_addr[AW-1:0]];
				fwd_q <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	// write in the same edge as the read: take the written value
	assign rd_data = fwd_q ? fwd_data_q : (vld_rd_q ? mem_rdata_q : 2'b00);

endmodule

@@ src/ksme_msg_buf.sv @@
// Message serializer: holds up to three messages of one sample, one beat out a cycle while out_ready is high.
// Depends on ksme_pkg and the assertion macro header.
`include "key_scan_to_midi_encoder_unit_defines.svh"
module ksme_msg_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  ksme_pkg::msg_load_t ld,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output ksme_pkg::msg_t      out_msg,
	output logic                out_last
);
	import ksme_pkg::*;

	msg_t [MAX_MSGS-1:0] msg_q;
	msg_cnt_t            cnt_q;
	msg_cnt_t            rd_q;
	logic                take;

	assign out_valid = (rd_q != cnt_q);
	assign take = out_valid && out_ready;
	assign free = (rd_q == cnt_q) || ((rd_q + 2'd1 == cnt_q) && out_ready);
	assign out_msg = msg_q[rd_q];
	assign out_last = (rd_q + 2'd1 == cnt_q);

	always_ff @(posedge clk) begin
		if (ld.load) begin
			msg_q <= ld.msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
		end else if (ld.load) begin
			cnt_q <= ld.cnt;
			rd_q <= '0;
		end else if (take) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	`KSME_ASSERT_NOW(a_load_when_free, clk, arst_n, ld.load, free)
	`KSME_ASSERT_NOW(a_load_cnt_ok, clk, arst_n, ld.load, (ld.cnt != 2'd0))
	`KSME_ASSERT_NOW(a_rd_in_range, clk, arst_n, 1'b1, (rd_q <= cnt_q))

endmodule

@@ src/key_scan_to_midi_encoder_unit.sv @@
// A sample waits in the stage 1 register until the serializer is free, then its messages load into it.
// Throughput: one sample per cycle while each causes at most one message and m_tready is high; a sample
// with several messages holds the input while the single serializing output register sends them.
// Reset: held flags read as released (per-entry valid bits cleared), volume 127,
// vibrato off, base note 48; no clearing pass, the block takes samples right after reset.
// Depends on ksme_pkg, ksme_held_mem, ksme_msg_buf and the assertion macro header.
`include "key_scan_to_midi_encoder_unit_defines.svh"
module key_scan_to_midi_encoder_unit #(
	parameter int SCAN_POSITIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [3:0] key_position, [4] row_one_level,
	                              // [5] row_two_level, [6] control_level, [7] zero
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] status_byte, [14:8] first_data,
	                              // [21:15] second_data, [23:22] zero
	output logic        m_tlast,  // last_message
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ksme_pkg::*;

	localparam logic [POS_W:0] SCAN_LIM = (POS_W+1)'(SCAN_POSITIONS);

	// config
	note_t base_q;

	// stage 1: sample waiting on held-flag read data
	logic  s1_valid_q;
	pos_t  pos_s1;
	logic  r1_s1;
	logic  r2_s1;
	logic  ctl_s1;

	// scalar state
	note_t vol_q;
	logic  vib_q;

	logic       in_take;
	logic [1:0] held;
	held_wr_t   wr;
	msg_load_t  ld;
	logic       buf_free;
	msg_t       out_msg;

	logic       in_range;
	logic       note_key;
	logic       chg1;
	logic       chg2;
	logic       vib_hit;
	note_t      note1;
	note_t      note2;
	logic       s1_adv;
	logic       ld_load;

	msg_t [MAX_MSGS-1:0] msgs;
	msg_cnt_t            msg_cnt;

	// APB: single register, writes land on the access cycle
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BASE_NOTE) ? {25'd0, base_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_NOTE_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BASE_NOTE)) begin
			base_q <= pwdata[NOTE_W-1:0];
		end
	end

	// stage 0: read the held flags of the incoming position
	assign in_take = s_tvalid && s_tready;

	ksme_held_mem #(
		.DEPTH (SCAN_POSITIONS)
	) u_held (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_take),
		.rd_addr (s_tdata[POS_W-1:0]),
		.wr      (wr),
		.rd_data (held)
	);

	always_ff @(posedge clk) begin
		if (in_take) begin
			pos_s1 <= s_tdata[POS_W-1:0];
			r1_s1 <= s_tdata[4];
			r2_s1 <= s_tdata[5];
			ctl_s1 <= s_tdata[6];
		end
	end

	// stage 1: edge detect against held flags, build messages
	assign in_range = ({1'b0, pos_s1} < SCAN_LIM);
	assign note_key = (pos_s1 < NOTE_KEYS);
	assign chg1 = (r1_s1 != held[0]) && note_key;
	assign chg2 = (r2_s1 != held[1]) && note_key;
	assign vib_hit = ctl_s1 && (pos_s1 == POS_VIBRATO);
	assign note1 = base_q + {3'b000, pos_s1};
	assign note2 = note1 + OCTAVE;

	always_comb begin
		msg_cnt_t n;
		n = '0;
		msgs = '0;
		if (chg1) begin
			msgs[n] = '{status: NOTE_STATUS, d1: note1, d2: (r1_s1 ? vol_q : MIN_LEVEL)};
			n = n + 2'd1;
		end
		if (chg2) begin
			msgs[n] = '{status: NOTE_STATUS, d1: note2, d2: (r2_s1 ? vol_q : MIN_LEVEL)};
			n = n + 2'd1;
		end
		if (vib_hit) begin
			msgs[n] = '{status: CTRL_STATUS, d1: MOD_CONTROLLER,
				d2: (vib_q ? MIN_LEVEL : MAX_LEVEL)};
			n = n + 2'd1;
		end
		msg_cnt = n;
	end

	// a sample with nothing to send never waits on the serializer
	assign s1_adv = s1_valid_q && (!in_range || (msg_cnt == 2'd0) || buf_free);
	assign ld_load = s1_adv && in_range && (msg_cnt != 2'd0);
	assign ld = '{load: ld_load, cnt: msg_cnt, msg: msgs};
	assign s_tready = !s1_valid_q || s1_adv;

	assign wr.en = s1_adv && in_range;
	assign wr.addr = pos_s1;
	assign wr.data = {r2_s1, r1_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			vol_q <= MAX_LEVEL;
			vib_q <= 1'b0;
		end else begin
			if (in_take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv && in_range && ctl_s1) begin
				priority if (pos_s1 == POS_VOL_DOWN) begin
					if (vol_q != MIN_LEVEL) vol_q <= vol_q - 7'd1;
				end else if (pos_s1 == POS_VOL_UP) begin
					if (vol_q != MAX_LEVEL) vol_q <= vol_q + 7'd1;
				end else if (pos_s1 == POS_VIBRATO) begin
					vib_q <= !vib_q;
				end else begin
					// control at other positions does nothing
				end
			end
		end
	end

	// output serializer
	ksme_msg_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.free      (buf_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_msg   (out_msg),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, out_msg.d2, out_msg.d1, out_msg.status};

	`KSME_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, (s1_valid_q && !s1_adv), !s_tready)
	`KSME_ASSERT_NXT(a_vibrato_toggles, clk, arst_n, (s1_adv && in_range && vib_hit),
		(vib_q != $past(vib_q)))
	`KSME_ASSERT_NXT(a_msgs_follow_load, clk, arst_n, ld_load, m_tvalid)

endmodule
